// ===== hdl/ffa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

    localparam int MAX_FREE_CHUNKS = 64;
    localparam int MAX_USED_CHUNKS = 64;
    localparam int OFFSET_BITS     = 20;

    localparam int LEN_W   = OFFSET_BITS + 1;
    localparam int SIZE_W  = LEN_W + 1;
    localparam int CNT_W   = 7;
    localparam int FIDX_W  = $clog2(MAX_FREE_CHUNKS);
    localparam int UIDX_W  = $clog2(MAX_USED_CHUNKS);
    localparam int ALIGN_W = 13;
    localparam int AMASK_W = ALIGN_W - 1;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [LEN_W-1:0]   ARENA_LIM   = LEN_W'(1) << OFFSET_BITS;
    localparam logic [LEN_W-1:0]   ARENA_RST   = LEN_W'(262144);
    localparam logic [ALIGN_W-1:0] ALIGN_RST   = ALIGN_W'(16);
    localparam logic [CNT_W-1:0]   FREE_MAX    = CNT_W'(MAX_FREE_CHUNKS);
    localparam logic [CNT_W-1:0]   USED_MAX    = CNT_W'(MAX_USED_CHUNKS);

    // register select is paddr[2]
    localparam logic REG_ARENA = 1'b0;
    localparam logic REG_ALIGN = 1'b1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADFREE = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic                   req_type;
        logic [LEN_W-1:0]       req_size;
        logic [OFFSET_BITS-1:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] block_offset;
        t_status                status;
        logic [LEN_W-1:0]       used_bytes;
        logic [LEN_W-1:0]       free_bytes;
        logic [CNT_W-1:0]       used_count;
        logic [CNT_W-1:0]       free_count;
    } t_rsp;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] off;
        logic [LEN_W-1:0]       len;
    } t_chunk;

    typedef struct packed {
        logic [LEN_W-1:0]   arena;
        logic [ALIGN_W-1:0] align;
    } t_cfg;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE,
        S_A_RND, S_A_START, S_A_SCAN, S_A_LEN, S_A_WHERE, S_A_USED,
        S_A_TOT_U, S_A_TOT_F, S_A_FWR,
        S_DEL_RD, S_DEL_WR,
        S_F_USTART, S_F_USCAN, S_F_PSTART, S_F_PSCAN, S_F_MP, S_F_MN, S_F_CHK,
        S_F_UWR, S_F_TOT_U, S_F_TOT_F, S_F_MERGE1, S_F_MERGE2, S_F_PWR,
        S_F_NEXT, S_F_NWR,
        S_INS_START, S_INS_RD, S_INS_WR, S_INS_PUT,
        S_FIN
    } t_state;

    // granule minus one; highest power of two not above the setting, zero acts as 1
    function automatic logic [AMASK_W-1:0] align_mask(input logic [ALIGN_W-1:0] a);
        logic [AMASK_W-1:0] m;
        m = '0;
        for (int i = 1; i < ALIGN_W; i++) begin
            if (a[i]) begin
                m = AMASK_W'((ALIGN_W'(1) << i) - ALIGN_W'(1));
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ffa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/ffa_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffa_alu
    import ffa_pkg::*;
(
    input  wire t_alu_op           i_op,
    input  wire logic [SIZE_W-1:0] i_a,
    input  wire logic [SIZE_W-1:0] i_b,
    output logic      [SIZE_W-1:0] o_y,
    output logic                   o_ge,
    output logic                   o_eq
);

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

    assign o_ge = (i_a >= i_b);
    assign o_eq = (i_a == i_b);

endmodule

`default_nettype wire

// ===== hdl/ffa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffa_ctrl
    import ffa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_arena_wr,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    t_state r_state, n_state;

    logic [LEN_W-1:0]       r_req_size, n_req_size;
    logic [OFFSET_BITS-1:0] r_at, n_at;
    logic [SIZE_W-1:0]      r_size, n_size;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_k, n_k;
    logic [CNT_W-1:0]       r_uidx, n_uidx;
    t_chunk                 r_chunk, n_chunk;
    t_chunk                 r_next, n_next;
    t_chunk                 r_blk, n_blk;
    logic                   r_has_next, n_has_next;
    logic                   r_mprev, n_mprev;
    logic                   r_mnext, n_mnext;
    logic [OFFSET_BITS-1:0] r_where, n_where;
    t_status                r_status, n_status;
    logic [CNT_W-1:0]       r_used_cnt, n_used_cnt;
    logic [CNT_W-1:0]       r_free_cnt, n_free_cnt;
    logic [LEN_W-1:0]       r_used_tot, n_used_tot;
    logic [LEN_W-1:0]       r_free_tot, n_free_tot;
    logic                   r_ovalid, n_ovalid;
    t_rsp                   r_rsp, n_rsp;

    logic              f_we, u_we;
    logic [FIDX_W-1:0] f_waddr, f_raddr;
    logic [UIDX_W-1:0] u_waddr, u_raddr;
    t_chunk            f_wdata, f_rdata, u_wdata, u_rdata;

    t_alu_op           alu_op;
    logic [SIZE_W-1:0] alu_a, alu_b, alu_y;
    logic              alu_ge, alu_eq;

    logic [LEN_W-1:0]   arena_sat;
    logic [AMASK_W-1:0] amask;
    logic [CNT_W-1:0]   idx_inc, uidx_inc;
    logic               req_acc, rsp_load;

    assign arena_sat = (i_cfg.arena > ARENA_LIM) ? ARENA_LIM : i_cfg.arena;
    assign amask     = align_mask(i_cfg.align);
    assign idx_inc   = r_idx + CNT_W'(1);
    assign uidx_inc  = r_uidx + CNT_W'(1);
    assign req_acc   = i_req_valid && (r_state == S_IDLE);
    assign rsp_load  = (r_state == S_FIN) && (!r_ovalid || i_rsp_ready);

    ffa_ram #(.WIDTH($bits(t_chunk)), .DEPTH(MAX_FREE_CHUNKS)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (f_we),
        .i_waddr(f_waddr),
        .i_wdata(f_wdata),
        .i_raddr(f_raddr),
        .o_rdata(f_rdata)
    );

    ffa_ram #(.WIDTH($bits(t_chunk)), .DEPTH(MAX_USED_CHUNKS)) u_used_ram (
        .i_clk  (i_clk),
        .i_we   (u_we),
        .i_waddr(u_waddr),
        .i_wdata(u_wdata),
        .i_raddr(u_raddr),
        .o_rdata(u_rdata)
    );

    ffa_alu u_alu (
        .i_op(alu_op),
        .i_a (alu_a),
        .i_b (alu_b),
        .o_y (alu_y),
        .o_ge(alu_ge),
        .o_eq(alu_eq)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (req_acc) begin
                    n_state = (i_req.req_type == REQ_FREE) ? S_F_USTART : S_A_RND;
                end
            end
            S_A_RND:   n_state = S_A_START;
            S_A_START: n_state = (r_size == '0) ? S_FIN : S_A_SCAN;
            S_A_SCAN: begin
                if (r_idx >= r_free_cnt) begin
                    n_state = S_FIN;
                end else if (alu_ge) begin
                    n_state = (r_used_cnt >= USED_MAX) ? S_FIN : S_A_LEN;
                end
            end
            S_A_LEN:   n_state = S_A_WHERE;
            S_A_WHERE: n_state = S_A_USED;
            S_A_USED:  n_state = S_A_TOT_U;
            S_A_TOT_U: n_state = S_A_TOT_F;
            S_A_TOT_F: n_state = (r_chunk.len != '0) ? S_A_FWR : S_DEL_RD;
            S_A_FWR:   n_state = S_FIN;
            S_DEL_RD:  n_state = (idx_inc >= r_free_cnt) ? S_FIN : S_DEL_WR;
            S_DEL_WR:  n_state = S_DEL_RD;
            S_F_USTART: n_state = S_F_USCAN;
            S_F_USCAN: begin
                if (r_uidx >= r_used_cnt) begin
                    n_state = S_FIN;
                end else if (alu_eq) begin
                    n_state = S_F_PSTART;
                end
            end
            S_F_PSTART: n_state = S_F_PSCAN;
            S_F_PSCAN: begin
                if (r_idx >= r_free_cnt || !alu_ge) begin
                    n_state = S_F_MP;
                end
            end
            S_F_MP: n_state = S_F_MN;
            S_F_MN: n_state = S_F_CHK;
            S_F_CHK: begin
                if (!r_mprev && !r_mnext && r_free_cnt >= FREE_MAX) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_F_UWR;
                end
            end
            S_F_UWR:   n_state = S_F_TOT_U;
            S_F_TOT_U: n_state = S_F_TOT_F;
            S_F_TOT_F: begin
                if (r_mprev) begin
                    n_state = S_F_MERGE1;
                end else if (r_mnext) begin
                    n_state = S_F_NEXT;
                end else begin
                    n_state = S_INS_START;
                end
            end
            S_F_MERGE1:  n_state = r_mnext ? S_F_MERGE2 : S_F_PWR;
            S_F_MERGE2:  n_state = S_F_PWR;
            S_F_PWR:     n_state = r_mnext ? S_DEL_RD : S_FIN;
            S_F_NEXT:    n_state = S_F_NWR;
            S_F_NWR:     n_state = S_FIN;
            S_INS_START: n_state = S_INS_RD;
            S_INS_RD:    n_state = (r_k == r_idx) ? S_INS_PUT : S_INS_WR;
            S_INS_WR:    n_state = S_INS_RD;
            S_INS_PUT:   n_state = S_FIN;
            S_FIN:       n_state = rsp_load ? S_IDLE : S_FIN;
            default:     n_state = S_INIT;
        endcase
        if (i_arena_wr) begin
            n_state = S_INIT;
        end
    end

    // datapath, memory ports and shared unit operands
    always_comb begin
        n_req_size = r_req_size;
        n_at       = r_at;
        n_size     = r_size;
        n_idx      = r_idx;
        n_k        = r_k;
        n_uidx     = r_uidx;
        n_chunk    = r_chunk;
        n_next     = r_next;
        n_blk      = r_blk;
        n_has_next = r_has_next;
        n_mprev    = r_mprev;
        n_mnext    = r_mnext;
        n_where    = r_where;
        n_status   = r_status;
        n_used_cnt = r_used_cnt;
        n_free_cnt = r_free_cnt;
        n_used_tot = r_used_tot;
        n_free_tot = r_free_tot;
        n_rsp      = r_rsp;
        n_ovalid   = r_ovalid && !i_rsp_ready;
        f_we       = 1'b0;
        f_waddr    = r_idx[FIDX_W-1:0];
        f_wdata    = r_chunk;
        f_raddr    = '0;
        u_we       = 1'b0;
        u_waddr    = r_used_cnt[UIDX_W-1:0];
        u_wdata    = r_blk;
        u_raddr    = '0;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;

        unique case (r_state)
            S_INIT: begin
                f_we       = 1'b1;
                f_waddr    = '0;
                f_wdata    = '{off: '0, len: arena_sat};
                n_free_cnt = (arena_sat != '0) ? CNT_W'(1) : '0;
                n_free_tot = arena_sat;
                n_used_cnt = '0;
                n_used_tot = '0;
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_req_size = i_req.req_size;
                    n_at       = i_req.free_offset;
                    n_where    = '0;
                    n_status   = ST_OK;
                end
            end
            S_A_RND: begin
                alu_a  = SIZE_W'(r_req_size);
                alu_b  = SIZE_W'(amask);
                n_size = alu_y & ~SIZE_W'(amask);
            end
            S_A_START: begin
                n_idx = '0;
                if (r_size == '0) begin
                    n_status = ST_NOSPACE;
                end
            end
            S_A_SCAN: begin
                alu_a   = SIZE_W'(f_rdata.len);
                alu_b   = r_size;
                f_raddr = idx_inc[FIDX_W-1:0];
                if (r_idx >= r_free_cnt) begin
                    n_status = ST_NOSPACE;
                end else if (alu_ge) begin
                    n_chunk = f_rdata;
                    if (r_used_cnt >= USED_MAX) begin
                        n_status = ST_FULL;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_A_LEN: begin
                alu_op      = ALU_SUB;
                alu_a       = SIZE_W'(r_chunk.len);
                alu_b       = r_size;
                n_chunk.len = alu_y[LEN_W-1:0];
            end
            S_A_WHERE: begin
                alu_a   = SIZE_W'(r_chunk.off);
                alu_b   = SIZE_W'(r_chunk.len);
                n_where = alu_y[OFFSET_BITS-1:0];
            end
            S_A_USED: begin
                u_we       = 1'b1;
                u_waddr    = r_used_cnt[UIDX_W-1:0];
                u_wdata    = '{off: r_where, len: r_size[LEN_W-1:0]};
                n_used_cnt = r_used_cnt + CNT_W'(1);
            end
            S_A_TOT_U: begin
                alu_a      = SIZE_W'(r_used_tot);
                alu_b      = r_size;
                n_used_tot = alu_y[LEN_W-1:0];
            end
            S_A_TOT_F: begin
                alu_op     = ALU_SUB;
                alu_a      = SIZE_W'(r_free_tot);
                alu_b      = r_size;
                n_free_tot = alu_y[LEN_W-1:0];
            end
            S_A_FWR: begin
                f_we    = 1'b1;
                f_waddr = r_idx[FIDX_W-1:0];
                f_wdata = r_chunk;
            end
            // close the gap at r_idx, moving each later entry down by one slot
            S_DEL_RD: begin
                f_raddr = idx_inc[FIDX_W-1:0];
                if (idx_inc >= r_free_cnt) begin
                    n_free_cnt = r_free_cnt - CNT_W'(1);
                end
            end
            S_DEL_WR: begin
                f_we    = 1'b1;
                f_waddr = r_idx[FIDX_W-1:0];
                f_wdata = f_rdata;
                n_idx   = idx_inc;
            end
            S_F_USTART: begin
                n_uidx = '0;
            end
            S_F_USCAN: begin
                alu_a   = SIZE_W'(u_rdata.off);
                alu_b   = SIZE_W'(r_at);
                u_raddr = uidx_inc[UIDX_W-1:0];
                if (r_uidx >= r_used_cnt) begin
                    n_status = ST_BADFREE;
                end else if (alu_eq) begin
                    n_blk = u_rdata;
                end else begin
                    n_uidx = uidx_inc;
                end
            end
            S_F_PSTART: begin
                n_idx      = '0;
                n_has_next = 1'b0;
            end
            // r_idx ends at the first chunk above the block; r_chunk holds the one below
            S_F_PSCAN: begin
                alu_a   = SIZE_W'(r_blk.off);
                alu_b   = SIZE_W'(f_rdata.off);
                f_raddr = idx_inc[FIDX_W-1:0];
                if (r_idx < r_free_cnt) begin
                    if (!alu_ge) begin
                        n_next     = f_rdata;
                        n_has_next = 1'b1;
                    end else begin
                        n_chunk = f_rdata;
                        n_idx   = idx_inc;
                    end
                end
            end
            S_F_MP: begin
                alu_a   = SIZE_W'(r_chunk.off);
                alu_b   = SIZE_W'(r_chunk.len);
                n_mprev = (r_idx != '0) && (alu_y == SIZE_W'(r_blk.off));
            end
            S_F_MN: begin
                alu_a   = SIZE_W'(r_blk.off);
                alu_b   = SIZE_W'(r_blk.len);
                n_mnext = r_has_next && (alu_y == SIZE_W'(r_next.off));
            end
            S_F_CHK: begin
                u_raddr = UIDX_W'(r_used_cnt - CNT_W'(1));
                if (!r_mprev && !r_mnext && r_free_cnt >= FREE_MAX) begin
                    n_status = ST_FULL;
                end
            end
            // last used entry moves into the freed slot
            S_F_UWR: begin
                u_we       = 1'b1;
                u_waddr    = r_uidx[UIDX_W-1:0];
                u_wdata    = u_rdata;
                n_used_cnt = r_used_cnt - CNT_W'(1);
            end
            S_F_TOT_U: begin
                alu_op     = ALU_SUB;
                alu_a      = SIZE_W'(r_used_tot);
                alu_b      = SIZE_W'(r_blk.len);
                n_used_tot = alu_y[LEN_W-1:0];
            end
            S_F_TOT_F: begin
                alu_a      = SIZE_W'(r_free_tot);
                alu_b      = SIZE_W'(r_blk.len);
                n_free_tot = alu_y[LEN_W-1:0];
            end
            S_F_MERGE1: begin
                alu_a       = SIZE_W'(r_chunk.len);
                alu_b       = SIZE_W'(r_blk.len);
                n_chunk.len = alu_y[LEN_W-1:0];
            end
            S_F_MERGE2: begin
                alu_a       = SIZE_W'(r_chunk.len);
                alu_b       = SIZE_W'(r_next.len);
                n_chunk.len = alu_y[LEN_W-1:0];
            end
            S_F_PWR: begin
                f_we    = 1'b1;
                f_waddr = FIDX_W'(r_idx - CNT_W'(1));
                f_wdata = r_chunk;
            end
            S_F_NEXT: begin
                alu_a      = SIZE_W'(r_next.len);
                alu_b      = SIZE_W'(r_blk.len);
                n_next.len = alu_y[LEN_W-1:0];
                n_next.off = r_blk.off;
            end
            S_F_NWR: begin
                f_we    = 1'b1;
                f_waddr = r_idx[FIDX_W-1:0];
                f_wdata = r_next;
            end
            S_INS_START: begin
                n_k = r_free_cnt;
            end
            // open a slot at r_idx, moving entries up from the top
            S_INS_RD: begin
                f_raddr = FIDX_W'(r_k - CNT_W'(1));
            end
            S_INS_WR: begin
                f_we    = 1'b1;
                f_waddr = r_k[FIDX_W-1:0];
                f_wdata = f_rdata;
                n_k     = r_k - CNT_W'(1);
            end
            S_INS_PUT: begin
                f_we       = 1'b1;
                f_waddr    = r_idx[FIDX_W-1:0];
                f_wdata    = r_blk;
                n_free_cnt = r_free_cnt + CNT_W'(1);
            end
            S_FIN: begin
                if (rsp_load) begin
                    n_ovalid = 1'b1;
                    n_rsp    = '{
                        block_offset: r_where,
                        status:       r_status,
                        used_bytes:   r_used_tot,
                        free_bytes:   r_free_tot,
                        used_count:   r_used_cnt,
                        free_count:   r_free_cnt
                    };
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_ovalid   <= 1'b0;
            r_used_cnt <= '0;
            r_free_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_ovalid   <= n_ovalid;
            r_used_cnt <= n_used_cnt;
            r_free_cnt <= n_free_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_size <= n_req_size;
        r_at       <= n_at;
        r_size     <= n_size;
        r_idx      <= n_idx;
        r_k        <= n_k;
        r_uidx     <= n_uidx;
        r_chunk    <= n_chunk;
        r_next     <= n_next;
        r_blk      <= n_blk;
        r_has_next <= n_has_next;
        r_mprev    <= n_mprev;
        r_mnext    <= n_mnext;
        r_where    <= n_where;
        r_status   <= n_status;
        r_used_tot <= n_used_tot;
        r_free_tot <= n_free_tot;
        r_rsp      <= n_rsp;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

// ===== hdl/first_fit_arena_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                  Dir  Payload
// request   i_req_valid / o_req_ready / i_req        in   t_req
// response  o_rsp_valid / i_rsp_ready / o_rsp        out  t_rsp
// config    psel penable pwrite paddr pwdata prdata  in   arena (0x0), align (0x4)
//
// Allocate: round the size, take the block from the top of the first chunk that fits
// and move later entries down if it empties. Free: find the used entry and the free
// position, merge with the chunk below, above or both, or move entries up and insert.
// One add/compare unit and one registered read per table do all the work. Reset and
// each arena write rebuild the free table in S_INIT. A finished response waits in its
// register while the next request is taken and held at its end.

module first_fit_arena_allocator_unit
    import ffa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire t_req              i_req,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output t_rsp                   o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg r_cfg;
    logic cfg_wr;
    logic arena_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign arena_wr = cfg_wr && (paddr[2] == REG_ARENA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{arena: ARENA_RST, align: ALIGN_RST};
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ARENA: r_cfg.arena <= pwdata[LEN_W-1:0];
                REG_ALIGN: r_cfg.align <= pwdata[ALIGN_W-1:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ARENA: prdata = APB_DW'(r_cfg.arena);
            REG_ALIGN: prdata = APB_DW'(r_cfg.align);
            default:   prdata = '0;
        endcase
    end

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_arena_wr (arena_wr),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

`ifndef SYNTH
    a_fail_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ST_OK) |-> (o_rsp.block_offset == '0))
        else $error("failed response carries an offset");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.used_count <= USED_MAX && o_rsp.free_count <= FREE_MAX))
        else $error("chunk count above table depth");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("ready right after taking a request");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_first_fit_arena_allocator_unit.sv =====
`timescale 1ns / 1ps

module tb_first_fit_arena_allocator_unit;
    import ffa_pkg::*;

    // Software copy of the allocator: tables, totals and settings.
    class arena_scoreboard;
        t_chunk      free_list[$];
        t_chunk      used_list[$];
        logic [LEN_W-1:0]   arena;
        logic [ALIGN_W-1:0] align;
        longint      used_sum;
        longint      free_sum;
        t_rsp        pending[$];
        int          mismatches;

        function void rebuild();
            longint sz;
            sz = (arena > ARENA_LIM) ? ARENA_LIM : arena;
            free_list.delete();
            used_list.delete();
            used_sum = 0;
            free_sum = sz;
            if (sz != 0) begin
                free_list.push_back('{off: '0, len: LEN_W'(sz)});
            end
        endfunction

        function void set_reg(logic sel, logic [31:0] v);
            if (sel == REG_ARENA) begin
                arena = v[LEN_W-1:0];
                rebuild();
            end else begin
                align = v[ALIGN_W-1:0];
            end
        endfunction

        function t_status do_alloc(longint req, output longint at);
            longint p, size;
            int i;
            p = 1;
            at = 0;
            while ((p << 1) <= align) p = p << 1;
            size = (req + p - 1) & ~(p - 1);
            if (size == 0) return ST_NOSPACE;
            for (i = 0; i < free_list.size(); i++)
                if (free_list[i].len >= size) break;
            if (i >= free_list.size()) return ST_NOSPACE;
            if (used_list.size() >= MAX_USED_CHUNKS) return ST_FULL;
            at = free_list[i].off + free_list[i].len - size;
            free_list[i].len = LEN_W'(free_list[i].len - size);
            if (free_list[i].len == 0) free_list.delete(i);
            used_list.push_back('{off: OFFSET_BITS'(at), len: LEN_W'(size)});
            used_sum += size;
            free_sum -= size;
            return ST_OK;
        endfunction

        function t_status do_free(longint at);
            int u, p;
            t_chunk blk;
            bit mp, mn;
            for (u = 0; u < used_list.size(); u++)
                if (used_list[u].off == at) break;
            if (u >= used_list.size()) return ST_BADFREE;
            blk = used_list[u];
            for (p = 0; p < free_list.size(); p++)
                if (free_list[p].off > blk.off) break;
            mp = p > 0 && longint'(free_list[p-1].off) + free_list[p-1].len == blk.off;
            mn = p < free_list.size() && longint'(blk.off) + blk.len == free_list[p].off;
            if (!mp && !mn && free_list.size() >= MAX_FREE_CHUNKS) return ST_FULL;
            used_list[u] = used_list[used_list.size()-1];
            used_list.pop_back();
            used_sum -= blk.len;
            free_sum += blk.len;
            if (mp && mn) begin
                free_list[p-1].len = free_list[p-1].len + blk.len + free_list[p].len;
                free_list.delete(p);
            end else if (mp) begin
                free_list[p-1].len = free_list[p-1].len + blk.len;
            end else if (mn) begin
                free_list[p].off = blk.off;
                free_list[p].len = free_list[p].len + blk.len;
            end else begin
                free_list.insert(p, blk);
            end
            return ST_OK;
        endfunction

        function void note_request(t_req r);
            t_rsp e;
            longint at;
            at = 0;
            if (r.req_type == REQ_ALLOC) e.status = do_alloc(r.req_size, at);
            else e.status = do_free(r.free_offset);
            if (e.status != ST_OK) at = 0;
            e.block_offset = at[OFFSET_BITS-1:0];
            e.used_bytes = used_sum[LEN_W-1:0];
            e.free_bytes = free_sum[LEN_W-1:0];
            e.used_count = CNT_W'(used_list.size());
            e.free_count = CNT_W'(free_list.size());
            pending.push_back(e);
        endfunction

        function void check_response(t_rsp a);
            t_rsp e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", a);
                return;
            end
            e = pending.pop_front();
            if (a.block_offset !== e.block_offset || a.status !== e.status ||
                a.used_bytes !== e.used_bytes || a.free_bytes !== e.free_bytes ||
                a.used_count !== e.used_count || a.free_count !== e.free_count) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch exp %p got %p", e, a);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_req_valid, o_req_ready, o_rsp_valid, i_rsp_ready;
    t_req i_req;
    t_rsp o_rsp;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;

    arena_scoreboard sb;
    int hold_cycles;

    first_fit_arena_allocator_unit u_top (.*);

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    initial begin
        #50ms;
        $display("** first_fit_arena_allocator_unit: FAILED **");
        $finish;
    end

    // response side: random stalls, plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) sb.check_response(o_rsp);
    end

    initial begin
        int w;
        i_rsp_ready = 1'b0;
        hold_cycles = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_rsp_ready <= 1'b0;
            end else if (i_rsp_ready && o_rsp_valid) begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                if (w != 0) begin
                    i_rsp_ready <= 1'b0;
                    repeat (w) @(posedge i_clk);
                end
                i_rsp_ready <= 1'b1;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(logic sel, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {sel, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(sel, v);
    endtask

    // valid drops only while idling; drain() takes it down after the last request
    task automatic send(logic kind, int size, int off, bit fast);
        t_req r;
        int w;
        r.req_type = kind;
        r.req_size = LEN_W'(size);
        r.free_offset = OFFSET_BITS'(off);
        w = fast ? 0 : $urandom_range(0, 9);
        if (w != 0) begin
            i_req_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(r);
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_req_valid <= 1'b0;
        while (sb.pending.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    // a live offset or, now and then, a bogus one
    function automatic int pick_free_offset();
        if (sb.used_list.size() != 0 && $urandom_range(0, 7) != 0)
            return int'(sb.used_list[$urandom_range(0, sb.used_list.size() - 1)].off);
        return $urandom_range(0, 20'hFFFFF);
    endfunction

    task automatic random_phase(int count, int size_max);
        int sz;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 1)) begin
                sz = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 21'h1FFFFF)
                                                   : $urandom_range(0, size_max);
                send(REQ_ALLOC, sz, $urandom, k % 50 < 10);
            end else begin
                send(REQ_FREE, $urandom, pick_free_offset(), k % 50 < 10);
            end
        end
        drain();
    endtask

    initial begin
        sb = new();
        sb.arena = ARENA_RST;
        sb.align = ALIGN_RST;
        sb.rebuild();
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // directed: extremes, zero size, bad and double free, exact fit
        send(REQ_ALLOC, 0, 0, 0);
        send(REQ_ALLOC, 1, 0, 0);
        send(REQ_ALLOC, 21'h1FFFFF, 20'hFFFFF, 0);
        send(REQ_ALLOC, 262144, 0, 0);
        send(REQ_FREE, 0, 20'hFFFFF, 0);
        send(REQ_FREE, 0, 262128, 0);
        send(REQ_FREE, 0, 262128, 0);
        send(REQ_ALLOC, 262144, 0, 0);
        send(REQ_FREE, 0, 0, 0);
        drain();

        reg_write(REG_ARENA, 32'h0);
        reg_write(REG_ALIGN, 32'h0);
        send(REQ_ALLOC, 1, 0, 0);
        drain();

        reg_write(REG_ARENA, 32'h1FFFFF);
        reg_write(REG_ALIGN, 32'h1FFF);
        send(REQ_ALLOC, 1, 0, 0);
        send(REQ_ALLOC, 1048576, 0, 0);
        drain();

        // small arena, byte granule: fill used table, fragment free table
        reg_write(REG_ARENA, 32'd300);
        reg_write(REG_ALIGN, 32'd1);
        for (int k = 0; k < 70; k++) send(REQ_ALLOC, 2, 0, 1);
        for (int k = 0; k < 64; k += 2) send(REQ_FREE, 0, 298 - 2 * k, 1);
        drain();
        random_phase(150, 12);

        // long receiver hold-off while requests keep coming
        reg_write(REG_ALIGN, 32'd3);
        hold_cycles = 2000;
        random_phase(120, 8);

        reg_write(REG_ARENA, 32'd4096);
        reg_write(REG_ALIGN, 32'd16);
        random_phase(300, 300);

        reg_write(REG_ARENA, 32'd1048576);
        reg_write(REG_ALIGN, 32'd100);
        random_phase(300, 40000);

        reg_write(REG_ARENA, 32'd777);
        reg_write(REG_ALIGN, 32'd2);
        random_phase(300, 40);

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("** first_fit_arena_allocator_unit: PASSED **");
        end else begin
            $display("** first_fit_arena_allocator_unit: FAILED **");
        end
        $finish;
    end
endmodule
